// ===== design/vac_pkg.sv =====
// Shared types, constants and calibration tables for the autoranging voltmeter core.
package vac_pkg;

    // Field and datapath widths
    localparam int ADC_W    = 12;
    localparam int TICK_W   = 32;
    localparam int GAIN_W   = 28;
    localparam int LEVEL_W  = 21;
    localparam int VOLT_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SLOPE_W  = 18;
    localparam int MUL_A_W  = 30;
    localparam int MUL_B_W  = 28;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC_SH  = 24;
    localparam int TERM_W   = PROD_W - FRAC_SH;   // rounded magnitude term
    localparam int SUM_W    = TERM_W + 2;         // signed term plus offset

    // Samples closer than this to the last range change are dropped
    localparam logic [TICK_W-1:0] HOLDOFF = 32'd1000;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SH - 1);
    localparam logic signed [SUM_W-1:0] VOLT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] VOLT_MIN = SUM_W'(-64'sd2147483648);

    // Range codes
    typedef logic [1:0] t_range;
    localparam t_range RANGE_OVER = 2'd0;
    localparam t_range RANGE_12   = 2'd1;
    localparam t_range RANGE_5    = 2'd2;
    localparam t_range RANGE_1    = 2'd3;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GAIN_12   = 3'd0;
    localparam t_cfg_idx CFG_GAIN_5    = 3'd1;
    localparam t_cfg_idx CFG_GAIN_1    = 3'd2;
    localparam t_cfg_idx CFG_OVER_LVL  = 3'd3;
    localparam t_cfg_idx CFG_UP12_LVL  = 3'd4;
    localparam t_cfg_idx CFG_UP5_LVL   = 3'd5;
    localparam t_cfg_idx CFG_DN5_LVL   = 3'd6;
    localparam t_cfg_idx CFG_DN1_LVL   = 3'd7;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_CAL,
        ST_DEC
    } t_state;

    // Slope magnitude per range, Q2.16 (all slopes are negative)
    function automatic logic [SLOPE_W-1:0] slope_mag(input t_range rng);
        logic [SLOPE_W-1:0] s;
        case (rng)
            RANGE_5: s = 18'd235602;
            RANGE_1: s = 18'd233551;
            default: s = 18'd233184;
        endcase
        return s;
    endfunction

    // Offset per range, Q2.16
    function automatic logic [SLOPE_W-1:0] offset_q16(input t_range rng);
        logic [SLOPE_W-1:0] o;
        case (rng)
            RANGE_5: o = 18'd66912;
            RANGE_1: o = 18'd11849;
            default: o = 18'd166638;
        endcase
        return o;
    endfunction

endpackage

// ===== design/vac_if.sv =====
// Valid/ready channel interfaces for sample items and result items.
interface vac_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [vac_pkg::ADC_W-1:0] adc_sample;
    logic [vac_pkg::TICK_W-1:0]      tick_now;
    logic                            fresh_sample;
    logic                            log_request;

    modport source (output valid, adc_sample, tick_now, fresh_sample, log_request,
                    input ready);
    modport sink   (input valid, adc_sample, tick_now, fresh_sample, log_request,
                    output ready);
endinterface

interface vac_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [vac_pkg::VOLT_W-1:0] volts;
    vac_pkg::t_range                  range_used;
    logic                             is_over_limit;
    vac_pkg::t_range                  next_range;
    logic                             range_changed;
    logic                             log_flag;

    modport source (output valid, volts, range_used, is_over_limit, next_range,
                    range_changed, log_flag, input ready);
    modport sink   (input valid, volts, range_used, is_over_limit, next_range,
                    range_changed, log_flag, output ready);
endinterface

// ===== design/vac_mul.sv =====
// Shared registered multiplier used for both calibration products.
module vac_mul (
    input  logic                        i_clk,
    input  logic [vac_pkg::MUL_A_W-1:0] i_a,
    input  logic [vac_pkg::MUL_B_W-1:0] i_b,
    output logic [vac_pkg::PROD_W-1:0]  o_prod
);

    logic [vac_pkg::PROD_W-1:0] r_prod;

    // Register the product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= vac_pkg::PROD_W'(i_a) * vac_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== design/voltmeter_autorange_calibrate_core.sv =====
// Top level of the autoranging voltmeter: calibration sequencer and range selection.
//
// Each accepted sample item is scaled by the active range's gain and slope, offset
// and saturated into a signed Q16.16 voltage, and then drives the range decision.
// One multiplier is shared by both products (count times slope, then times gain),
// so the input is not ready again until the item's result has been loaded into the
// output register: a new item is taken only once the last one is through. A sample
// inside the holdoff window after a range change is dropped in the first multiply
// step and gives no result. The result sits in an output register; a stalled
// result holds the sequencer in its last step.
// Configuration writes are taken at any edge with the write enable high.
module voltmeter_autorange_calibrate_core #(
    parameter logic [vac_pkg::TICK_W-1:0] HOLDOFF = vac_pkg::HOLDOFF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vac_in_if.sink                        i_in,
    vac_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  vac_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [vac_pkg::GAIN_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [vac_pkg::GAIN_W-1:0]  r_gain_12, r_gain_5, r_gain_1;
    logic [vac_pkg::LEVEL_W-1:0] r_over_lvl, r_up12_lvl, r_up5_lvl, r_dn5_lvl, r_dn1_lvl;

    // Sequencer and range state
    vac_pkg::t_state             r_state, n_state;
    vac_pkg::t_range             r_range;
    logic [vac_pkg::TICK_W-1:0]  r_last_tick;

    // Captured item
    logic signed [vac_pkg::ADC_W-1:0] r_sample;
    logic [vac_pkg::TICK_W-1:0]  r_tick;
    logic                        r_fresh;
    logic                        r_log;

    // Calibrated voltage
    logic signed [vac_pkg::VOLT_W-1:0] r_volts;

    // Output register
    logic                        r_out_valid;
    logic signed [vac_pkg::VOLT_W-1:0] r_out_volts;
    vac_pkg::t_range             r_out_used, r_out_next;
    logic                        r_out_over, r_out_changed, r_out_log;

    // Multiplier operands and strobes
    logic [vac_pkg::MUL_A_W-1:0] mul_a;
    logic [vac_pkg::MUL_B_W-1:0] mul_b;
    logic [vac_pkg::PROD_W-1:0]  prod;
    logic                        take_in, ld_volts, ld_out, out_free;

    vac_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Holdoff check on the captured tick
    logic [vac_pkg::TICK_W-1:0] tick_diff;
    logic                       drop;
    assign tick_diff = r_tick - r_last_tick;
    assign drop      = tick_diff < HOLDOFF;

    // Sample magnitude (the negative scale is symmetric)
    logic                        neg;
    logic [vac_pkg::ADC_W-1:0]   adc_mag;
    assign neg     = r_sample[vac_pkg::ADC_W-1];
    assign adc_mag = neg ? (~r_sample + vac_pkg::ADC_W'(1)) : r_sample;

    // Gain of the active range; the over-limit range uses the 12 V gain
    logic [vac_pkg::GAIN_W-1:0] gain_sel;
    always_comb begin
        case (r_range)
            vac_pkg::RANGE_5: gain_sel = r_gain_5;
            vac_pkg::RANGE_1: gain_sel = r_gain_1;
            default:          gain_sel = r_gain_12;
        endcase
    end

    // Round, sign, offset and saturate the final product
    logic [vac_pkg::PROD_W-1:0]        rnd_sum;
    logic [vac_pkg::TERM_W-1:0]        term_mag;
    logic signed [vac_pkg::SUM_W-1:0]  term, off, v_sum;
    logic signed [vac_pkg::VOLT_W-1:0] v_sat;
    always_comb begin
        rnd_sum  = prod + vac_pkg::ROUND_HALF;
        term_mag = rnd_sum[vac_pkg::PROD_W-1:vac_pkg::FRAC_SH];
        term     = neg ? $signed({2'b00, term_mag}) : -$signed({2'b00, term_mag});
        off      = $signed(vac_pkg::SUM_W'(vac_pkg::offset_q16(r_range)));
        v_sum    = term + off;
        if (v_sum > vac_pkg::VOLT_MAX) begin
            v_sat = vac_pkg::VOLT_W'(vac_pkg::VOLT_MAX);
        end else if (v_sum < vac_pkg::VOLT_MIN) begin
            v_sat = vac_pkg::VOLT_W'(vac_pkg::VOLT_MIN);
        end else begin
            v_sat = v_sum[vac_pkg::VOLT_W-1:0];
        end
    end

    // Range decision on the voltage magnitude
    logic [vac_pkg::VOLT_W-1:0] v_mag;
    logic                       over;
    vac_pkg::t_range            want;
    logic                       changed;
    always_comb begin
        v_mag = r_volts[vac_pkg::VOLT_W-1] ? (~r_volts + vac_pkg::VOLT_W'(1)) : r_volts;
        over  = v_mag >= vac_pkg::VOLT_W'(r_over_lvl);
        if (over) begin
            want = vac_pkg::RANGE_OVER;
        end else if (v_mag >= vac_pkg::VOLT_W'(r_up12_lvl)) begin
            want = vac_pkg::RANGE_12;
        end else if (v_mag >= vac_pkg::VOLT_W'(r_up5_lvl) &&
                     v_mag <= vac_pkg::VOLT_W'(r_dn5_lvl)) begin
            want = vac_pkg::RANGE_5;
        end else if (v_mag <= vac_pkg::VOLT_W'(r_dn1_lvl)) begin
            want = vac_pkg::RANGE_1;
        end else begin
            want = r_range;
        end
        changed = r_fresh && (want != r_range);
    end

    assign out_free = !r_out_valid || o_out.ready;

    // Next state and multiplier steering
    always_comb begin
        n_state  = r_state;
        mul_a    = '0;
        mul_b    = '0;
        take_in  = 1'b0;
        ld_volts = 1'b0;
        ld_out   = 1'b0;
        case (r_state)
            vac_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    take_in = 1'b1;
                    n_state = vac_pkg::ST_MUL1;
                end
            end
            vac_pkg::ST_MUL1: begin
                mul_a = vac_pkg::MUL_A_W'(adc_mag);
                mul_b = vac_pkg::MUL_B_W'(vac_pkg::slope_mag(r_range));
                n_state = drop ? vac_pkg::ST_IDLE : vac_pkg::ST_MUL2;
            end
            vac_pkg::ST_MUL2: begin
                mul_a   = prod[vac_pkg::MUL_A_W-1:0];
                mul_b   = gain_sel;
                n_state = vac_pkg::ST_CAL;
            end
            vac_pkg::ST_CAL: begin
                ld_volts = 1'b1;
                n_state  = vac_pkg::ST_DEC;
            end
            vac_pkg::ST_DEC: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = vac_pkg::ST_IDLE;
                end
            end
            default: n_state = vac_pkg::ST_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == vac_pkg::ST_IDLE);

    // Advance the sequencer and range state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vac_pkg::ST_IDLE;
            r_range     <= vac_pkg::RANGE_12;
            r_last_tick <= '0;
        end else begin
            r_state <= n_state;
            if (ld_out && changed) begin
                r_range     <= want;
                r_last_tick <= r_tick;
            end
        end
    end

    // Capture the item and the calibrated voltage
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_sample <= i_in.adc_sample;
            r_tick   <= i_in.tick_now;
            r_fresh  <= i_in.fresh_sample;
            r_log    <= i_in.log_request;
        end
        if (ld_volts) begin
            r_volts <= v_sat;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_volts   <= r_volts;
            r_out_used    <= r_range;
            r_out_over    <= over;
            r_out_next    <= changed ? want : r_range;
            r_out_changed <= changed;
            r_out_log     <= r_log;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.volts         = r_out_volts;
    assign o_out.range_used    = r_out_used;
    assign o_out.is_over_limit = r_out_over;
    assign o_out.next_range    = r_out_next;
    assign o_out.range_changed = r_out_changed;
    assign o_out.log_flag      = r_out_log;

    // Write configuration registers; levels keep their low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_12  <= 28'd16777216;
            r_gain_5   <= 28'd16777216;
            r_gain_1   <= 28'd16777216;
            r_over_lvl <= 21'd851968;
            r_up12_lvl <= 21'd360448;
            r_up5_lvl  <= 21'd72090;
            r_dn5_lvl  <= 21'd294912;
            r_dn1_lvl  <= 21'd58982;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vac_pkg::CFG_GAIN_12:  r_gain_12  <= i_cfg_data;
                vac_pkg::CFG_GAIN_5:   r_gain_5   <= i_cfg_data;
                vac_pkg::CFG_GAIN_1:   r_gain_1   <= i_cfg_data;
                vac_pkg::CFG_OVER_LVL: r_over_lvl <= i_cfg_data[vac_pkg::LEVEL_W-1:0];
                vac_pkg::CFG_UP12_LVL: r_up12_lvl <= i_cfg_data[vac_pkg::LEVEL_W-1:0];
                vac_pkg::CFG_UP5_LVL:  r_up5_lvl  <= i_cfg_data[vac_pkg::LEVEL_W-1:0];
                vac_pkg::CFG_DN5_LVL:  r_dn5_lvl  <= i_cfg_data[vac_pkg::LEVEL_W-1:0];
                vac_pkg::CFG_DN1_LVL:  r_dn1_lvl  <= i_cfg_data[vac_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== test/voltmeter_autorange_calibrate_core_tb.sv =====
// Self-checking testbench for the autoranging voltmeter calibration core.
`timescale 1ns / 1ps

module voltmeter_autorange_calibrate_core_tb;

    localparam int  CLK_PERIOD      = 10;
    localparam int  SETTLE_CYCLES   = 12;
    localparam int  LONG_HOLD       = 400;
    localparam int  N_PHASES        = 8;
    localparam int  ITEMS_PER_PHASE = 237;
    localparam longint TIMEOUT_CYCLES = 500000;
    localparam longint VOLT_HI      = 64'sd2147483647;
    localparam longint VOLT_LO      = -64'sd2147483648;

    // One sample item as offered to the block
    typedef struct packed {
        logic signed [vac_pkg::ADC_W-1:0] adc;
        logic [vac_pkg::TICK_W-1:0]       tick;
        logic                             fresh;
        logic                             log_req;
    } t_sample;

    // One reading item as produced by the block
    typedef struct packed {
        logic signed [vac_pkg::VOLT_W-1:0] volts;
        vac_pkg::t_range                   range_used;
        logic                              over_limit;
        vac_pkg::t_range                   next_range;
        logic                              changed;
        logic                              log_flag;
    } t_reading;

    typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {EXP_MODEL, EXP_DROP, EXP_TYPED} t_expect_kind;

    // One row of the directed plan
    typedef struct packed {
        t_row_kind                   kind;
        vac_pkg::t_cfg_idx           idx;
        logic [vac_pkg::GAIN_W-1:0]  data;
        t_sample                     smp;
        t_expect_kind                check;
        t_reading                    want;
    } t_plan_row;

    localparam t_reading NO_READING = '0;
    localparam t_sample  NO_SAMPLE  = '0;
    localparam vac_pkg::t_cfg_idx NO_IDX = vac_pkg::CFG_GAIN_12;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                       cfg_we;
    vac_pkg::t_cfg_idx          cfg_idx;
    logic [vac_pkg::GAIN_W-1:0] cfg_data;

    vac_in_if  smp_if ();
    vac_out_if rdg_if ();

    voltmeter_autorange_calibrate_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (smp_if),
        .o_out      (rdg_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Register copies and range state of the predictor
    logic [vac_pkg::GAIN_W-1:0]  gain12, gain5, gain1;
    logic [vac_pkg::LEVEL_W-1:0] lvl_over, lvl_up12, lvl_up5, lvl_dn5, lvl_dn1;
    vac_pkg::t_range             cur_range;
    logic [vac_pkg::TICK_W-1:0]  last_switch;

    t_reading pending_readings [$];
    int       fail_count = 0;
    int       sender_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       long_hold_req = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Work out the reading for one accepted sample; return 0 when it is dropped
    function automatic logic predict_reading(input t_sample s, output t_reading r);
        logic [12:0]                cnt_mag;
        logic [vac_pkg::GAIN_W-1:0] gain;
        logic [63:0]                slope, offs, prod;
        longint                     v, vmag;
        vac_pkg::t_range            want;
        r = NO_READING;
        if (s.tick - last_switch < vac_pkg::HOLDOFF)
            return 1'b0;

        cnt_mag = s.adc[vac_pkg::ADC_W-1] ? 13'h1000 - {1'b0, s.adc} : {1'b0, s.adc};
        case (cur_range)
            vac_pkg::RANGE_5: begin
                gain = gain5;  slope = 64'd235602; offs = 64'd66912;
            end
            vac_pkg::RANGE_1: begin
                gain = gain1;  slope = 64'd233551; offs = 64'd11849;
            end
            default: begin
                gain = gain12; slope = 64'd233184; offs = 64'd166638;
            end
        endcase

        // Round the magnitude term half away from zero, then apply sign and offset
        prod = 64'(cnt_mag) * 64'(gain) * slope;
        prod = (prod + (64'd1 << 23)) >> 24;
        v = s.adc[vac_pkg::ADC_W-1] ? longint'(prod) : -longint'(prod);
        v = v + longint'(offs);
        if (v > VOLT_HI)
            v = VOLT_HI;
        if (v < VOLT_LO)
            v = VOLT_LO;
        vmag = (v < 0) ? -v : v;

        r.volts      = v[vac_pkg::VOLT_W-1:0];
        r.range_used = cur_range;
        r.over_limit = (vmag >= lvl_over);
        r.next_range = cur_range;
        r.changed    = 1'b0;
        r.log_flag   = s.log_req;

        // Pick the new range: first test that holds wins
        if (s.fresh) begin
            want = cur_range;
            if (r.over_limit)
                want = vac_pkg::RANGE_OVER;
            else if (vmag >= lvl_up12)
                want = vac_pkg::RANGE_12;
            else if (vmag >= lvl_up5 && vmag <= lvl_dn5)
                want = vac_pkg::RANGE_5;
            else if (vmag <= lvl_dn1)
                want = vac_pkg::RANGE_1;
            if (want != cur_range) begin
                r.next_range = want;
                r.changed    = 1'b1;
                cur_range    = want;
                last_switch  = s.tick;
            end
        end
        return 1'b1;
    endfunction

    // Write one register at the next edge; the caller lowers the write enable
    task automatic write_reg(input vac_pkg::t_cfg_idx idx,
                             input logic [vac_pkg::GAIN_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            vac_pkg::CFG_GAIN_12:  gain12   = data;
            vac_pkg::CFG_GAIN_5:   gain5    = data;
            vac_pkg::CFG_GAIN_1:   gain1    = data;
            vac_pkg::CFG_OVER_LVL: lvl_over = data[vac_pkg::LEVEL_W-1:0];
            vac_pkg::CFG_UP12_LVL: lvl_up12 = data[vac_pkg::LEVEL_W-1:0];
            vac_pkg::CFG_UP5_LVL:  lvl_up5  = data[vac_pkg::LEVEL_W-1:0];
            vac_pkg::CFG_DN5_LVL:  lvl_dn5  = data[vac_pkg::LEVEL_W-1:0];
            vac_pkg::CFG_DN1_LVL:  lvl_dn1  = data[vac_pkg::LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one sample item, wait for acceptance, record what it should produce
    task automatic send_sample(input t_sample s, input t_expect_kind check,
                               input t_reading typed);
        t_reading r;
        logic     has;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            smp_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        smp_if.valid        <= 1'b1;
        smp_if.adc_sample   <= s.adc;
        smp_if.tick_now     <= s.tick;
        smp_if.fresh_sample <= s.fresh;
        smp_if.log_request  <= s.log_req;
        do @(posedge i_clk); while (!smp_if.ready);
        has = predict_reading(s, r);
        case (check)
            EXP_MODEL: if (has) pending_readings.push_back(r);
            EXP_TYPED: pending_readings.push_back(typed);
            default: ;
        endcase
    endtask

    // Stop offering, wait for every expected reading, then let dropped items clear
    task automatic wait_for_readings();
        smp_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drive the result side: random stalls plus an occasional long hold-off
    initial begin : reading_sink
        int hold_left;
        hold_left = 0;
        rdg_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (!i_rst_n) begin
                rdg_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                rdg_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rdg_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Compare each accepted reading with the oldest expectation
    always @(posedge i_clk) begin : check_readings
        t_reading want;
        if (i_rst_n && rdg_if.valid && rdg_if.ready) begin
            if (pending_readings.size() == 0) begin
                $error("reading with nothing expected: volts %0d", rdg_if.volts);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                if (rdg_if.volts !== want.volts) begin
                    $error("volts: expected %0d, got %0d", want.volts, rdg_if.volts);
                    fail_count++;
                end
                if (rdg_if.range_used !== want.range_used) begin
                    $error("range_used: expected %0d, got %0d",
                           want.range_used, rdg_if.range_used);
                    fail_count++;
                end
                if (rdg_if.is_over_limit !== want.over_limit) begin
                    $error("is_over_limit: expected %0d, got %0d",
                           want.over_limit, rdg_if.is_over_limit);
                    fail_count++;
                end
                if (rdg_if.next_range !== want.next_range) begin
                    $error("next_range: expected %0d, got %0d",
                           want.next_range, rdg_if.next_range);
                    fail_count++;
                end
                if (rdg_if.range_changed !== want.changed) begin
                    $error("range_changed: expected %0d, got %0d",
                           want.changed, rdg_if.range_changed);
                    fail_count++;
                end
                if (rdg_if.log_flag !== want.log_flag) begin
                    $error("log_flag: expected %0d, got %0d",
                           want.log_flag, rdg_if.log_flag);
                    fail_count++;
                end
            end
        end
    end

    // Main stimulus: directed plan, then randomized phases
    initial begin : stimulus
        t_plan_row                  plan [$];
        t_sample                    s;
        logic [vac_pkg::TICK_W-1:0] tick_cursor;
        logic [vac_pkg::GAIN_W-1:0] g12_v, g5_v, g1_v;
        logic [vac_pkg::GAIN_W-1:0] over_v, up12_v, up5_v, dn5_v, dn1_v;
        int unsigned                base;

        smp_if.valid        = 1'b0;
        smp_if.adc_sample   = '0;
        smp_if.tick_now     = '0;
        smp_if.fresh_sample = 1'b0;
        smp_if.log_request  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = vac_pkg::CFG_GAIN_12;
        cfg_data = '0;
        i_rst_n  = 1'b0;

        gain12   = 28'd16777216;
        gain5    = 28'd16777216;
        gain1    = 28'd16777216;
        lvl_over = 21'd851968;
        lvl_up12 = 21'd360448;
        lvl_up5  = 21'd72090;
        lvl_dn5  = 21'd294912;
        lvl_dn1  = 21'd58982;
        cur_range   = vac_pkg::RANGE_12;
        last_switch = '0;

        // Directed plan: reset holdoff, sample extremes, a move into every range,
        // holdoff after a change, masked level write, tick wrap, zero gain
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'd0, 1'b1, 1'b0},
                         EXP_DROP, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'd999, 1'b1, 1'b0},
                         EXP_DROP, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'd1000, 1'b0, 1'b1},
                         EXP_TYPED,
                         '{32'sd166638, vac_pkg::RANGE_12, 1'b0,
                           vac_pkg::RANGE_12, 1'b0, 1'b1}});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd2047, 32'd2000, 1'b0, 1'b0},
                         EXP_TYPED,
                         '{-32'sd477161010, vac_pkg::RANGE_12, 1'b1,
                           vac_pkg::RANGE_12, 1'b0, 1'b0}});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{-12'sd2048, 32'd3000, 1'b0, 1'b1},
                         EXP_TYPED,
                         '{32'sd477727470, vac_pkg::RANGE_12, 1'b1,
                           vac_pkg::RANGE_12, 1'b0, 1'b1}});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'd4000, 1'b1, 1'b0},
                         EXP_TYPED,
                         '{32'sd166638, vac_pkg::RANGE_12, 1'b0,
                           vac_pkg::RANGE_5, 1'b1, 1'b0}});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'd4999, 1'b1, 1'b0},
                         EXP_DROP, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'd5000, 1'b1, 1'b0},
                         EXP_TYPED,
                         '{32'sd66912, vac_pkg::RANGE_5, 1'b0,
                           vac_pkg::RANGE_5, 1'b0, 1'b0}});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd1, 32'd6000, 1'b1, 1'b1},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{-12'sd1, 32'd7000, 1'b1, 1'b0},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd2, 32'd8000, 1'b1, 1'b0},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd100, 32'd9000, 1'b1, 1'b1},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'd10000, 1'b1, 1'b0},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_CFG, vac_pkg::CFG_GAIN_5, 28'h0400000, NO_SAMPLE,
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd1, 32'd11000, 1'b1, 1'b0},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{-12'sd2048, 32'd12000, 1'b1, 1'b1},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_CFG, vac_pkg::CFG_DN1_LVL, 28'hFFFFFFF, NO_SAMPLE,
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'hFFFFFF00, 1'b1, 1'b0},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'h00000100, 1'b1, 1'b0},
                         EXP_DROP, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd0, 32'h000003E8, 1'b1, 1'b0},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_CFG, vac_pkg::CFG_GAIN_12, 28'd0, NO_SAMPLE,
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{12'sd2047, 32'h00010000, 1'b1, 1'b0},
                         EXP_MODEL, NO_READING});
        plan.push_back('{ROW_ITEM, NO_IDX, '0, '{-12'sd2048, 32'h00020000, 1'b0, 1'b1},
                         EXP_TYPED,
                         '{32'sd166638, vac_pkg::RANGE_OVER, 1'b0,
                           vac_pkg::RANGE_OVER, 1'b0, 1'b1}});

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed plan
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_for_readings();
                write_reg(plan[i].idx, plan[i].data);
                cfg_we <= 1'b0;
            end else begin
                send_sample(plan[i].smp, plan[i].check, plan[i].want);
            end
        end

        // Random phases, each with its own register setting and idling mode
        tick_cursor = 32'h00030000;
        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_for_readings();
            case (phase)
                1: begin
                    g12_v = '0; g5_v = '0; g1_v = '0;
                    over_v = '0; up12_v = '0; up5_v = '0; dn5_v = '0; dn1_v = '0;
                end
                5: begin
                    // All ones: full gains, levels masked down to their width
                    g12_v = '1; g5_v = '1; g1_v = '1;
                    over_v = '1; up12_v = '1; up5_v = '1; dn5_v = '1; dn1_v = '1;
                end
                7: begin
                    g12_v = 28'd16777216; g5_v = 28'd16777216; g1_v = 28'd16777216;
                    over_v = 28'd851968; up12_v = 28'd360448; up5_v = 28'd72090;
                    dn5_v = 28'd294912; dn1_v = 28'd58982;
                end
                default: begin
                    g12_v = 28'($urandom_range(4096, 300000));
                    g5_v  = 28'($urandom_range(4096, 300000));
                    g1_v  = 28'($urandom_range(4096, 300000));
                    if ($urandom_range(0, 3) == 0) begin
                        // Unordered levels: windows overlap or vanish
                        over_v = 28'($urandom_range(0, 1310720));
                        up12_v = 28'($urandom_range(0, 1310720));
                        up5_v  = 28'($urandom_range(0, 1310720));
                        dn5_v  = 28'($urandom_range(0, 1310720));
                        dn1_v  = 28'($urandom_range(0, 1310720));
                    end else begin
                        base   = $urandom_range(0, 150000);
                        dn1_v  = 28'(base);
                        base   = base + $urandom_range(0, 60000);
                        up5_v  = 28'(base);
                        base   = base + $urandom_range(0, 400000);
                        dn5_v  = 28'(base);
                        base   = base + $urandom_range(0, 150000);
                        up12_v = 28'(base);
                        base   = base + $urandom_range(0, 700000);
                        over_v = 28'(base);
                    end
                end
            endcase
            write_reg(vac_pkg::CFG_GAIN_12, g12_v);
            write_reg(vac_pkg::CFG_GAIN_5, g5_v);
            write_reg(vac_pkg::CFG_GAIN_1, g1_v);
            write_reg(vac_pkg::CFG_OVER_LVL, over_v);
            write_reg(vac_pkg::CFG_UP12_LVL, up12_v);
            write_reg(vac_pkg::CFG_UP5_LVL, up5_v);
            write_reg(vac_pkg::CFG_DN5_LVL, dn5_v);
            write_reg(vac_pkg::CFG_DN1_LVL, dn1_v);
            cfg_we <= 1'b0;

            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin sender_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            // Hold off the result side while samples keep coming, to back up the input
            if (phase % 3 == 0)
                long_hold_req = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Advance the tick: mostly past the holdoff, sometimes inside or wrapping
                case ($urandom_range(0, 19))
                    0:       tick_cursor = $urandom();
                    1:       tick_cursor = 32'hFFFFFFFF - 32'($urandom_range(0, 3000));
                    2, 3, 4: tick_cursor = tick_cursor + 32'($urandom_range(0, 999));
                    default: tick_cursor = tick_cursor + 32'($urandom_range(1000, 4000));
                endcase
                if ($urandom_range(0, 1) == 0)
                    s.adc = 12'($urandom_range(0, 4095));
                else
                    s.adc = 12'($urandom_range(0, 127)) - 12'sd64;
                s.tick    = tick_cursor;
                s.fresh   = ($urandom_range(0, 99) < 75);
                s.log_req = 1'($urandom_range(0, 1));
                send_sample(s, EXP_MODEL, NO_READING);
            end
        end

        wait_for_readings();
        if (fail_count == 0)
            $display("voltmeter_autorange_calibrate_core: match");
        else
            $display("voltmeter_autorange_calibrate_core: mismatch");
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("voltmeter_autorange_calibrate_core: mismatch");
        $finish;
    end

endmodule
